FILE: rtl/ssrlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrlm_pkg
// Shared types and constants of the stereo slot swap level meter.
// ----------------------------------------------------------------------------
package ssrlm_pkg;
    localparam int unsigned DEF_MAX_BLOCK_FRAMES = 1024;
    localparam int LEVEL_W = 11;
    localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -11'sd900;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               block_end;
    } ssrlm_word_t;
endpackage
`default_nettype wire

FILE: rtl/stereo_slot_swap_rms_level_meter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_slot_swap_rms_level_meter_core
// Stereo slot swap with block RMS level meter in tenths of dBFS.
// ----------------------------------------------------------------------------
// Each input word is one stereo frame, right slot in the low half. A frame
// is returned swapped, left sample in the low bits and the held levels above
// the samples, once it has passed the input register and the output register.
// A word marked tlast closes a block; its levels come from the shared iterative
// log2 unit run three times (frame count, then each channel sum, up to 44
// normalise steps and 16 squaring steps each); the input stalls meanwhile.
// A one-word input register decouples the input from the computation.
module stereo_slot_swap_rms_level_meter_core
    import ssrlm_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // first_slot_sample, second_slot_sample
    input  wire logic        s_tlast,  // block_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // left_sample, right_sample, left_level_ddb, right_level_ddb
    output logic [55:0]      m_tdata,
    output logic             m_tuser   // level_updated
);
    logic        q_valid, q_ready;
    ssrlm_word_t q_word;

    ssrlm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .q_valid(q_valid), .q_ready(q_ready),
        .q_word(q_word)
    );

    ssrlm_back #(.MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_word(q_word), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );
endmodule
`default_nettype wire

FILE: rtl/ssrlm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrlm_front
// Input stage: splits the word into its two samples and registers one word for the queue.
// ----------------------------------------------------------------------------
module ssrlm_front
    import ssrlm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             q_valid,
    input  wire logic        q_ready,
    output ssrlm_word_t      q_word
);
    logic        valid_reg;
    ssrlm_word_t word_reg;

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_word   = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            word_reg.left_sample  <= s_tdata[31:16];
            word_reg.right_sample <= s_tdata[15:0];
            word_reg.block_end    <= s_tlast;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ssrlm_log2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrlm_log2
// Iterative log2 in Q16: finds the top bit a step at a time, then squares
// the mantissa once per fraction bit.
// ----------------------------------------------------------------------------
module ssrlm_log2 #(
    parameter int unsigned X_W = 48
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [X_W-1:0] x,
    output logic                done,
    output logic [23:0]         result
);
    typedef enum logic [1:0] {L_IDLE, L_NORM, L_FRAC} lstate_t;
    localparam int P_W = $clog2(X_W) + 1;

    lstate_t        state_reg;
    logic [X_W-1:0] x_reg;
    logic [P_W-1:0] p_reg;
    logic [31:0]    m_reg;
    logic [4:0]     i_reg;
    logic [23:0]    r_reg;
    logic [63:0]    sq;
    logic [33:0]    msq;

    assign sq     = {32'd0, m_reg} * {32'd0, m_reg};
    assign msq    = sq[63:30];
    assign done   = (state_reg == L_IDLE);
    assign result = r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        x_reg     <= x;
                        p_reg     <= P_W'(X_W - 1);
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (x_reg[X_W-1] || p_reg == '0) begin
                        m_reg     <= {1'b0, x_reg[X_W-1 -: 31]};
                        r_reg     <= {8'(p_reg), 16'd0};
                        i_reg     <= 5'd15;
                        state_reg <= L_FRAC;
                    end else begin
                        x_reg <= x_reg << 1;
                        p_reg <= p_reg - 1'b1;
                    end
                end
                L_FRAC: begin
                    if (msq[31]) begin
                        m_reg <= msq[32:1];
                        r_reg[i_reg[3:0]] <= 1'b1;
                    end else begin
                        m_reg <= msq[31:0];
                    end
                    if (i_reg == 5'd0) state_reg <= L_IDLE;
                    i_reg <= i_reg - 1'b1;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ssrlm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrlm_back
// Accumulates squares, computes block levels on block end, issues results.
// ----------------------------------------------------------------------------
module ssrlm_back
    import ssrlm_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  ssrlm_word_t      q_word,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,
    output logic             m_tuser
);
    localparam int N_W   = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int SUM_W = 30 + N_W + 1;
    localparam int X_W   = SUM_W + 2;

    typedef enum logic [2:0] {B_IDLE, B_LOGN, B_LOGS, B_CALC, B_OUT} bstate_t;

    bstate_t               state_reg;
    logic [SUM_W-1:0]      lsum_reg, rsum_reg;
    logic [N_W-1:0]        n_reg;
    logic signed [10:0]    lhold_reg, rhold_reg;
    logic                  upd_reg, valid_reg, ch_reg;
    logic                  valid_next;
    logic signed [15:0]    lout_reg, rout_reg;
    logic [23:0]           a_reg;
    logic [SUM_W-1:0]      s_sel;
    logic                  lg_start, lg_done;
    logic [X_W-1:0]        lg_x;
    logic [23:0]           lg_r;
    logic [31:0]           lsq, rsq;
    logic [24:0]           diff;
    logic [56:0]           prod;
    logic [24:0]           mag;
    logic signed [10:0]    lvl;
    logic                  quiet, room;

    ssrlm_log2 #(.X_W(X_W)) u_log2 (
        .aclk(aclk), .aresetn(aresetn), .start(lg_start), .x(lg_x),
        .done(lg_done), .result(lg_r)
    );

    assign lsq   = 32'($signed(q_word.left_sample) * $signed(q_word.left_sample));
    assign rsq   = 32'($signed(q_word.right_sample) * $signed(q_word.right_sample));
    assign room  = (32'(n_reg) < 32'(MAX_BLOCK_FRAMES));
    assign s_sel = ch_reg ? rsum_reg : lsum_reg;
    assign quiet = (n_reg == '0) || ({s_sel, 2'b00} <= X_W'(n_reg));
    assign diff  = {1'b0, a_reg} - {1'b0, lg_r};
    assign prod  = 57'(diff) * 57'd1972830 + 57'h80000000;
    assign mag   = prod[56:32];
    assign lvl   = quiet ? LEVEL_FLOOR :
                   diff[24] || diff == '0 ? 11'sd0 :
                   mag > 25'd900 ? LEVEL_FLOOR : -$signed(11'(mag));

    assign q_ready  = (state_reg == B_IDLE) && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, rhold_reg, lhold_reg, rout_reg, lout_reg};
    assign m_tuser  = upd_reg;

    always_comb begin
        lg_start = 1'b0;
        lg_x     = '0;
        if (state_reg == B_IDLE && q_valid && q_ready && q_word.block_end) begin
            lg_start = 1'b1;
            lg_x     = X_W'(room ? n_reg + 1'b1 : n_reg);
        end else if (state_reg == B_LOGN && lg_done) begin
            lg_start = 1'b1;
            lg_x     = X_W'(lsum_reg);
        end else if (state_reg == B_CALC && !ch_reg) begin
            lg_start = 1'b1;
            lg_x     = X_W'(rsum_reg);
        end
    end

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (state_reg == B_IDLE && q_valid && q_ready && !q_word.block_end) begin
            valid_next = 1'b1;
        end else if (state_reg == B_OUT) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
            lsum_reg  <= '0;
            rsum_reg  <= '0;
            n_reg     <= '0;
            lhold_reg <= LEVEL_FLOOR;
            rhold_reg <= LEVEL_FLOOR;
            upd_reg   <= 1'b0;
            ch_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            unique case (state_reg)
                B_IDLE: begin
                    if (q_valid && q_ready) begin
                        lout_reg <= q_word.left_sample;
                        rout_reg <= q_word.right_sample;
                        if (room) begin
                            lsum_reg <= lsum_reg + SUM_W'(lsq);
                            rsum_reg <= rsum_reg + SUM_W'(rsq);
                            n_reg    <= n_reg + 1'b1;
                        end
                        if (q_word.block_end) begin
                            state_reg <= B_LOGN;
                        end else begin
                            upd_reg   <= 1'b0;
                        end
                    end
                end
                B_LOGN: begin
                    if (lg_done) begin
                        a_reg     <= lg_r + {8'd30, 16'd0};
                        ch_reg    <= 1'b0;
                        state_reg <= B_LOGS;
                    end
                end
                B_LOGS: begin
                    if (lg_done) state_reg <= B_CALC;
                end
                B_CALC: begin
                    if (!ch_reg) begin
                        lhold_reg <= lvl;
                        ch_reg    <= 1'b1;
                        state_reg <= B_LOGS;
                    end else begin
                        rhold_reg <= lvl;
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    lsum_reg  <= '0;
                    rsum_reg  <= '0;
                    n_reg     <= '0;
                    upd_reg   <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != B_IDLE |-> !q_ready)
        else $error("queue read during level computation");
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(n_reg) <= 32'(MAX_BLOCK_FRAMES))
        else $error("frame count beyond block limit");
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo slot swap RMS level meter.
// Frames go in as stream words. Every returned word is compared with the
// predicted swapped frame and the held block levels. The levels are
// predicted with the same fixed-point log2 arithmetic that the block uses.
// ----------------------------------------------------------------------------
module tb_top;
    import ssrlm_pkg::*;

    localparam int unsigned BLOCK_LIMIT = DEF_MAX_BLOCK_FRAMES;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam longint unsigned TENTHS_PER_LOG2 = 64'd1972830;

    typedef struct {
        logic [15:0]        left_sample;
        logic [15:0]        right_sample;
        logic               level_updated;
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
    } swapped_frame_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    swapped_frame_t expected_frames[$];
    longint unsigned left_sq_sum, right_sq_sum;
    int unsigned frame_count;
    logic signed [LEVEL_W-1:0] held_left, held_right;
    int mismatches = 0;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;
    bit holding = 1'b0;
    event start_hold;

    stereo_slot_swap_rms_level_meter_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        if (no_gaps || $urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint unsigned log2_q16(longint unsigned x);
        int unsigned p;
        longint unsigned t, m, r;
        p = 0;
        t = x;
        while (t > 1) begin
            t = t >> 1;
            p++;
        end
        m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        r = longint'(p) << 16;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] block_level(longint unsigned s,
                                                               int unsigned n);
        longint unsigned a, b, mag;
        if (n == 0 || s * 4 <= n) return LEVEL_FLOOR;
        a = (64'd30 << 16) + log2_q16(n);
        b = log2_q16(s);
        if (b >= a) return '0;
        mag = ((a - b) * TENTHS_PER_LOG2 + (64'd1 << 31)) >> 32;
        if (mag > 900) return LEVEL_FLOOR;
        return -LEVEL_W'(mag);
    endfunction

    function automatic void predict_frame(logic signed [15:0] right, logic signed [15:0] left,
                                          logic last);
        swapped_frame_t f;
        longint signed l, r;
        l = left;
        r = right;
        if (frame_count < BLOCK_LIMIT) begin
            left_sq_sum += longint'(l * l);
            right_sq_sum += longint'(r * r);
            frame_count++;
        end
        if (last) begin
            held_left = block_level(left_sq_sum, frame_count);
            held_right = block_level(right_sq_sum, frame_count);
            left_sq_sum = 0;
            right_sq_sum = 0;
            frame_count = 0;
        end
        f.left_sample = left;
        f.right_sample = right;
        f.level_updated = last;
        f.left_level = held_left;
        f.right_level = held_right;
        expected_frames.push_back(f);
    endfunction

    task automatic send_frame(input logic signed [15:0] right, input logic signed [15:0] left,
                              input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {left, right};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        predict_frame(right, left, last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] random_sample(int unsigned bits);
        logic [15:0] v;
        v = 16'($urandom());
        if (bits < 16) v = 16'($signed(v) >>> (16 - bits));
        return v;
    endfunction

    task automatic test_extremes();
        send_frame(16'sh7FFF, -16'sd32768, 1'b1);
        send_frame(-16'sd32768, 16'sh7FFF, 1'b0);
        send_frame(16'sh5555, 16'shAAAA, 1'b0);
        send_frame(16'shAAAA, 16'sh5555, 1'b1);
        send_frame(16'sd0, 16'sd0, 1'b0);
        send_frame(-16'sd1, 16'sd1, 1'b1);
    endtask

    task automatic test_quiet_and_loud();
        send_frame(16'sd0, 16'sd0, 1'b1);
        send_frame(16'sd0, 16'sd1, 1'b0);
        send_frame(16'sd0, 16'sd0, 1'b0);
        send_frame(16'sd0, 16'sd0, 1'b0);
        send_frame(16'sd0, 16'sd0, 1'b1);
        send_frame(-16'sd32768, -16'sd32768, 1'b0);
        send_frame(-16'sd32768, -16'sd32768, 1'b1);
        send_frame(16'sd1, -16'sd1, 1'b0);
        send_frame(-16'sd1, 16'sd1, 1'b1);
        send_frame(16'sd3, -16'sd2, 1'b0);
        send_frame(16'sd2, 16'sd30, 1'b1);
    endtask

    task automatic test_overlong_block();
        no_gaps = 1'b1;
        for (int i = 0; i < BLOCK_LIMIT + 6; i++)
            send_frame(random_sample(16), (i < BLOCK_LIMIT) ? 16'sd1 : -16'sd32768, 1'b0);
        send_frame(-16'sd32768, -16'sd32768, 1'b1);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_blocks(input int unsigned frames);
        int unsigned sent, len, lbits, rbits;
        sent = 0;
        while (sent < frames) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 8) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
                lbits = $urandom_range(1, 16);
                rbits = $urandom_range(1, 16);
                for (int i = 1; i <= len; i++)
                    send_frame(random_sample(rbits), random_sample(lbits), i == len);
                sent += len;
            end else begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_frame(16'($urandom()), 16'($urandom()), $urandom_range(0, 3) == 0);
                sent += len;
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        no_gaps = 1'b1;
        -> start_hold;
        for (int i = 0; i < 40; i++)
            send_frame(random_sample(16), random_sample(12), (i % 7) == 6);
        no_gaps = 1'b0;
        drain();
        test_random_blocks(30);
    endtask

    always @(start_hold) begin
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || holding) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(0, 9) < 7) || ($urandom_range(0, 19) == 0);
        end
    end

    always @(posedge aclk) begin
        swapped_frame_t f;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected word %h %h", m_tdata, m_tuser);
            end else begin
                f = expected_frames.pop_front();
                if (m_tdata[15:0] !== f.left_sample || m_tdata[31:16] !== f.right_sample
                        || m_tuser !== f.level_updated
                        || m_tdata[42:32] !== f.left_level
                        || m_tdata[53:43] !== f.right_level) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected L %h R %h upd %b lvl %0d/%0d, got %h %h",
                                 f.left_sample, f.right_sample, f.level_updated,
                                 $signed(f.left_level), $signed(f.right_level),
                                 m_tdata, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        left_sq_sum = 0;
        right_sq_sum = 0;
        frame_count = 0;
        held_left = LEVEL_FLOOR;
        held_right = LEVEL_FLOOR;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_quiet_and_loud();
        test_overlong_block();
        drain();
        test_random_blocks(400);
        test_backpressure();
        drain();
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
